[hw/rtl/dcfr_pkg.sv]
// Shared types and constants of the daisy-chain frame router.
// Used by every module of the router; depends on nothing else.
`default_nettype none

package dcfr_pkg;

  // Line bytes and frame type codes
  localparam logic [7:0] MagicByte   = 8'hAB;
  localparam logic [7:0] TypeAddrSet = 8'h00;
  localparam logic [7:0] TypeRetOff  = 8'h10;
  localparam logic [7:0] TypeRetOn   = 8'h11;
  localparam logic [7:0] TypePing    = 8'h20;
  localparam logic [7:0] TypeStat    = 8'h30;
  localparam logic [7:0] TypeImgNew  = 8'h40;
  localparam logic [7:0] TypeImgApp  = 8'h41;
  localparam logic [7:0] TypePrep    = 8'h50;
  localparam logic [7:0] TypeTrig    = 8'h51;
  localparam logic [7:0] TypeAck     = 8'hF0;
  localparam logic [7:0] TypeNack    = 8'hF1;
  localparam logic [7:0] AddrBcast   = 8'hFF;
  localparam logic [7:0] AddrHost    = 8'hFE;

  // Header byte positions after the magic byte
  localparam logic [2:0] HdrIdxType  = 3'd0;
  localparam logic [2:0] HdrIdxSrc   = 3'd1;
  localparam logic [2:0] HdrIdxDst   = 3'd2;
  localparam logic [2:0] HdrIdxLenLo = 3'd3;
  localparam logic [2:0] HdrIdxLenHi = 3'd4;

  // Reply frame is six bytes long
  localparam int unsigned ReplyLastIdx = 5;
  // Forwarded frame carries a six-byte header
  localparam int unsigned FwdHdrLen    = 6;

  // Depth of the input and result queues
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PhHunt,
    PhHeader,
    PhData
  } phase_e;

  typedef enum logic [1:0] {
    RpNone,
    RpAck,
    RpNack
  } reply_e;

  typedef enum logic [1:0] {
    ClsSlot,
    ClsMagic,
    ClsData
  } cls_e;

  typedef enum logic [3:0] {
    ActAddrSet,
    ActRetOff,
    ActRetOn,
    ActPing,
    ActStatus,
    ActImgNew,
    ActImgApp,
    ActPrep,
    ActTrigger
  } action_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [3:0] action;
    logic [7:0] action_arg;
    logic [8:0] action_len;
    logic       return_enabled;
    logic       overrun;
  } res_t;

  // Classified item as handed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [7:0] data;
  } fq_item_t;

endpackage

`default_nettype wire

[hw/rtl/dcfr_front.sv]
// Front end of the router: accepts items, tags each one as transmit slot,
// magic byte or plain byte, and holds them in a short queue. Uses dcfr_pkg.
`default_nettype none

module dcfr_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  input  dcfr_pkg::in_item_t   in_item_i,
  output logic                 full,
  output logic                 item_valid_o,
  output dcfr_pkg::fq_item_t   item_o,
  input  wire                  item_pop_i
);

  localparam int unsigned Depth = dcfr_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dcfr_pkg::fq_item_t entry_q [Depth];
  dcfr_pkg::fq_item_t cls_item;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               wr_en, rd_en;

  // Classify the incoming item
  always_comb begin
    cls_item.data = in_item_i.rx_byte;
    if (in_item_i.kind) begin
      cls_item.cls = dcfr_pkg::ClsSlot;
    end else if (in_item_i.rx_byte == dcfr_pkg::MagicByte) begin
      cls_item.cls = dcfr_pkg::ClsMagic;
    end else begin
      cls_item.cls = dcfr_pkg::ClsData;
    end
  end

  assign full         = (cnt_q == CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = entry_q[rd_ptr_q];
  assign wr_en        = push && !full;
  assign rd_en        = item_pop_i && item_valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcfr_outq.sv]
// Result queue of the router: holds finished result items until the
// receiver pops them. Uses dcfr_pkg.
`default_nettype none

module dcfr_outq (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              res_push_i,
  input  dcfr_pkg::res_t   res_i,
  output logic             res_full_o,
  output logic             empty,
  output dcfr_pkg::res_t   out_item_o,
  input  wire              pop
);

  localparam int unsigned Depth = dcfr_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dcfr_pkg::res_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign res_full_o = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);
  assign out_item_o = entry_q[rd_ptr_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the result item
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcfr_back.sv]
// Back end of the router: frame parser, executor, payload buffer and the
// reply / forward transmit sequencer. Uses dcfr_pkg.
`default_nettype none

module dcfr_back #(
  parameter int unsigned MaxPayload = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 item_valid_i,
  input  dcfr_pkg::fq_item_t  item_i,
  output logic                item_pop_o,
  input  wire                 res_full_i,
  output logic                res_push_o,
  output dcfr_pkg::res_t      res_o
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned CntW  = $clog2(MaxPayload + 1);
  localparam int unsigned SendW = $clog2(MaxPayload + dcfr_pkg::FwdHdrLen);

  // Parser state
  dcfr_pkg::phase_e phase_q, phase_d;
  logic [2:0]       hdr_idx_q, hdr_idx_d;
  logic [7:0]       ftype_q, ftype_d, fsrc_q, fsrc_d, fdst_q, fdst_d;
  logic [15:0]      flen_q, flen_d;
  logic [CntW-1:0]  data_cnt_q, data_cnt_d;
  logic [7:0]       data0_q, data0_d;

  // Node and transmit state
  logic [7:0]       own_q, own_d;
  logic             ret_q, ret_d;
  dcfr_pkg::reply_e reply_q, reply_d;
  logic             fwd_q, fwd_d;
  logic [SendW-1:0] send_idx_q, send_idx_d;
  logic             dropped_q, dropped_d;

  // Payload buffer
  logic [7:0]       payload_mem [MaxPayload];
  logic [7:0]       rd_data_q;
  logic [AddrW-1:0] rd_addr;

  // Step decode
  logic             fire, is_slot, busy, rx_live;
  logic             hdr_step, hdr_last, data_step, hunt_magic;
  logic [15:0]      len_new;
  logic             len_over, hdr_zero, data_done, complete;
  logic [7:0]       data0_c;
  logic [15:0]      len_c;
  logic             mem_we;

  // Executor outputs
  logic             local_hit, evt;
  dcfr_pkg::action_e act;
  logic [7:0]       arg, own_n;
  logic             ret_n, fwd_n;
  dcfr_pkg::reply_e rp;

  // Transmit byte selection
  logic [7:0]       reply_byte, fwd_byte;
  logic             reply_last, fwd_last;
  logic [16:0]      fwd_total;

  assign fire       = item_valid_i && !res_full_i;
  assign item_pop_o = fire;
  assign is_slot    = (item_i.cls == dcfr_pkg::ClsSlot);
  assign busy       = (reply_q != dcfr_pkg::RpNone) || fwd_q;
  assign rx_live    = fire && !is_slot && !busy;

  assign hdr_step   = rx_live && (phase_q == dcfr_pkg::PhHeader);
  assign data_step  = rx_live && (phase_q == dcfr_pkg::PhData);
  assign hunt_magic = rx_live && (phase_q == dcfr_pkg::PhHunt) &&
                      (item_i.cls == dcfr_pkg::ClsMagic);
  assign hdr_last   = hdr_step && (hdr_idx_q == dcfr_pkg::HdrIdxLenHi);
  assign len_new    = {item_i.data, flen_q[7:0]};
  assign len_over   = (len_new > 16'(MaxPayload));
  assign hdr_zero   = hdr_last && (len_new == 16'd0);
  assign data_done  = data_step && (16'(data_cnt_q) + 16'd1 >= flen_q);
  assign complete   = hdr_zero || data_done;
  assign len_c      = hdr_zero ? 16'd0 : flen_q;
  assign data0_c    = (data_cnt_q == '0) ? item_i.data : data0_q;
  assign mem_we     = data_step && (32'(data_cnt_q) < MaxPayload);

  // Execute the completed frame
  always_comb begin
    local_hit = (fdst_q == own_q) || (fdst_q == dcfr_pkg::AddrBcast);
    evt       = 1'b0;
    act       = dcfr_pkg::ActAddrSet;
    arg       = '0;
    own_n     = own_q;
    ret_n     = ret_q;
    rp        = dcfr_pkg::RpNone;
    if (local_hit) begin
      rp = dcfr_pkg::RpAck;
      unique case (ftype_q)
        dcfr_pkg::TypeAddrSet: begin
          if (len_c != 16'd1) begin
            rp = dcfr_pkg::RpNack;
          end else begin
            own_n = data0_c;
            evt   = 1'b1;
            act   = dcfr_pkg::ActAddrSet;
            arg   = data0_c;
            rp    = dcfr_pkg::RpNone;
          end
        end
        dcfr_pkg::TypeRetOff: begin
          if (len_c != 16'd0) begin
            rp = dcfr_pkg::RpNack;
          end else begin
            ret_n = 1'b0;
            evt   = 1'b1;
            act   = dcfr_pkg::ActRetOff;
            rp    = dcfr_pkg::RpNone;
          end
        end
        dcfr_pkg::TypeRetOn: begin
          if (len_c != 16'd0) begin
            rp = dcfr_pkg::RpNack;
          end else begin
            ret_n = 1'b1;
            evt   = 1'b1;
            act   = dcfr_pkg::ActRetOn;
          end
        end
        dcfr_pkg::TypePing: begin
          evt = 1'b1;
          act = dcfr_pkg::ActPing;
        end
        dcfr_pkg::TypeStat: begin
          if (len_c != 16'd1) begin
            rp = dcfr_pkg::RpNack;
          end else begin
            evt = 1'b1;
            act = dcfr_pkg::ActStatus;
            arg = data0_c;
          end
        end
        dcfr_pkg::TypeImgNew: begin
          evt = 1'b1;
          act = dcfr_pkg::ActImgNew;
        end
        dcfr_pkg::TypeImgApp: begin
          evt = 1'b1;
          act = dcfr_pkg::ActImgApp;
        end
        dcfr_pkg::TypePrep: begin
          evt = 1'b1;
          act = dcfr_pkg::ActPrep;
        end
        dcfr_pkg::TypeTrig: begin
          evt = 1'b1;
          act = dcfr_pkg::ActTrigger;
        end
        default: begin
          rp = dcfr_pkg::RpAck;
        end
      endcase
    end
    // forward test uses the address after execution
    fwd_n = (fdst_q == dcfr_pkg::AddrBcast) || (fdst_q != own_n);
  end

  // Select the next reply byte
  always_comb begin
    unique case (send_idx_q)
      SendW'(0): reply_byte = dcfr_pkg::MagicByte;
      SendW'(1): reply_byte = (reply_q == dcfr_pkg::RpNack) ? dcfr_pkg::TypeNack
                                                            : dcfr_pkg::TypeAck;
      SendW'(2): reply_byte = own_q;
      SendW'(3): reply_byte = dcfr_pkg::AddrHost;
      default:   reply_byte = '0;
    endcase
    reply_last = (32'(send_idx_q) >= dcfr_pkg::ReplyLastIdx);
  end

  // Select the next forwarded byte
  always_comb begin
    unique case (send_idx_q)
      SendW'(0): fwd_byte = dcfr_pkg::MagicByte;
      SendW'(1): fwd_byte = ftype_q;
      SendW'(2): fwd_byte = fsrc_q;
      SendW'(3): fwd_byte = fdst_q;
      SendW'(4): fwd_byte = flen_q[7:0];
      SendW'(5): fwd_byte = flen_q[15:8];
      default:   fwd_byte = rd_data_q;
    endcase
    fwd_total = {1'b0, flen_q} + 17'(dcfr_pkg::FwdHdrLen);
    fwd_last  = (17'(send_idx_q) + 17'd1 >= fwd_total);
  end

  // Parser next state
  always_comb begin
    phase_d = phase_q;
    priority if (complete) begin
      phase_d = dcfr_pkg::PhHunt;
    end else if (hdr_last) begin
      phase_d = len_over ? dcfr_pkg::PhHunt : dcfr_pkg::PhData;
    end else if (hunt_magic) begin
      phase_d = dcfr_pkg::PhHeader;
    end else begin
      phase_d = phase_q;
    end
  end

  // Datapath and transmit sequencer updates
  always_comb begin
    hdr_idx_d  = hdr_idx_q;
    ftype_d    = ftype_q;
    fsrc_d     = fsrc_q;
    fdst_d     = fdst_q;
    flen_d     = flen_q;
    data_cnt_d = data_cnt_q;
    data0_d    = data0_q;
    own_d      = own_q;
    ret_d      = ret_q;
    reply_d    = reply_q;
    fwd_d      = fwd_q;
    send_idx_d = send_idx_q;
    dropped_d  = dropped_q;
    res_push_o = 1'b0;
    res_o      = '0;

    // drop a received byte while output is pending
    if (fire && !is_slot && busy) begin
      dropped_d = 1'b1;
    end

    if (hunt_magic) begin
      hdr_idx_d = '0;
    end

    // capture header fields
    if (hdr_step) begin
      unique case (hdr_idx_q)
        dcfr_pkg::HdrIdxType:  ftype_d = item_i.data;
        dcfr_pkg::HdrIdxSrc:   fsrc_d  = item_i.data;
        dcfr_pkg::HdrIdxDst:   fdst_d  = item_i.data;
        dcfr_pkg::HdrIdxLenLo: flen_d  = {8'h00, item_i.data};
        default:               flen_d  = len_new;
      endcase
      if (hdr_last) begin
        hdr_idx_d  = '0;
        data_cnt_d = '0;
      end else begin
        hdr_idx_d = hdr_idx_q + 3'd1;
      end
    end

    // count data bytes, keep the first one for short commands
    if (data_step) begin
      data_cnt_d = data_cnt_q + 1'b1;
      if (data_cnt_q == '0) begin
        data0_d = item_i.data;
      end
    end

    // complete the frame
    if (complete) begin
      hdr_idx_d  = '0;
      send_idx_d = '0;
      own_d      = own_n;
      ret_d      = ret_n;
      reply_d    = rp;
      fwd_d      = fwd_n;
      if (evt) begin
        res_push_o           = 1'b1;
        res_o.out_kind       = 1'b1;
        res_o.action         = act;
        res_o.action_arg     = arg;
        res_o.action_len     = len_c[8:0];
        res_o.return_enabled = ret_n;
        res_o.overrun        = dropped_q;
      end
    end

    // hand out one transmit byte per slot, reply first
    if (fire && is_slot) begin
      if (reply_q != dcfr_pkg::RpNone) begin
        res_push_o           = 1'b1;
        res_o.tx_byte        = reply_byte;
        res_o.tx_last        = reply_last;
        res_o.return_enabled = ret_q;
        res_o.overrun        = dropped_q;
        if (reply_last) begin
          reply_d    = dcfr_pkg::RpNone;
          send_idx_d = '0;
        end else begin
          send_idx_d = send_idx_q + 1'b1;
        end
      end else if (fwd_q) begin
        res_push_o           = 1'b1;
        res_o.tx_byte        = fwd_byte;
        res_o.tx_last        = fwd_last;
        res_o.return_enabled = ret_q;
        res_o.overrun        = dropped_q;
        if (fwd_last) begin
          fwd_d      = 1'b0;
          send_idx_d = '0;
        end else begin
          send_idx_d = send_idx_q + 1'b1;
        end
      end
    end
  end

  // Prefetch the payload byte for the next forward position
  always_comb begin
    if (32'(send_idx_d) >= dcfr_pkg::FwdHdrLen) begin
      rd_addr = AddrW'(send_idx_d - SendW'(dcfr_pkg::FwdHdrLen));
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      payload_mem[data_cnt_q[AddrW-1:0]] <= item_i.data;
    end
    rd_data_q <= payload_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dcfr_pkg::PhHunt;
      hdr_idx_q  <= '0;
      ftype_q    <= '0;
      fsrc_q     <= '0;
      fdst_q     <= '0;
      flen_q     <= '0;
      own_q      <= '0;
      ret_q      <= 1'b0;
      reply_q    <= dcfr_pkg::RpNone;
      fwd_q      <= 1'b0;
      send_idx_q <= '0;
      dropped_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_idx_q  <= hdr_idx_d;
      ftype_q    <= ftype_d;
      fsrc_q     <= fsrc_d;
      fdst_q     <= fdst_d;
      flen_q     <= flen_d;
      own_q      <= own_d;
      ret_q      <= ret_d;
      reply_q    <= reply_d;
      fwd_q      <= fwd_d;
      send_idx_q <= send_idx_d;
      dropped_q  <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_cnt_q <= data_cnt_d;
    data0_q    <= data0_d;
  end

  // Reply position never runs past the six-byte reply
  a_reply_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reply_q != dcfr_pkg::RpNone) |-> (32'(send_idx_q) <= dcfr_pkg::ReplyLastIdx))
    else $error("reply index out of range");

  // While collecting data the count stays below the frame length
  a_data_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dcfr_pkg::PhData) |-> (16'(data_cnt_q) < flen_q))
    else $error("data count reached frame length in data phase");

  // Transmit sequencer restarts at zero after a frame completes
  a_send_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> (send_idx_q == '0))
    else $error("send index not cleared on frame completion");

  // No result is produced into a full result queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

endmodule

`default_nettype wire

[hw/rtl/daisy_chain_frame_router.sv]
// Top level of the daisy-chain frame router.
// Instantiates dcfr_front, dcfr_back and dcfr_outq; uses dcfr_pkg.
//
// Usage:
//   Input channel (push / full / in_item_i): one item per accepted push,
//   either a received line byte (kind 0) or a transmit slot (kind 1).
//   Result channel (empty / pop / out_item_o): the oldest result is shown
//   while empty is low and leaves on pop. A transmit slot yields the next
//   byte of the pending reply or forwarded frame; a completed local frame
//   may yield one action event.
//   Path: the input queue registers each accepted item; the back end is
//   combinational and writes its result into the result queue, which holds
//   it until it is popped.
//   Throughput: one item per cycle while the result queue is not full,
//   set by the back end handling one item per cycle; payload bytes of a
//   forwarded frame are registered from the payload buffer ahead of their slot.
//   Reset: all queues empty, parser hunting for the magic byte, address 0,
//   return path off, nothing pending, overrun flag clear. No clearing pass.
//   Receiver stall: the result queue fills, the back end stops taking items,
//   then the input queue fills and full rises; no item is lost.
`default_nettype none

module daisy_chain_frame_router #(
  parameter int unsigned MaxPayload = 256
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  input  dcfr_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  output dcfr_pkg::res_t      out_item_o,
  input  wire                 pop
);

  logic               item_valid, item_pop;
  dcfr_pkg::fq_item_t item;
  logic               res_push, res_full;
  dcfr_pkg::res_t     res;

  dcfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .in_item_i    (in_item_i),
    .full         (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  dcfr_back #(
    .MaxPayload (MaxPayload)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  dcfr_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .out_item_o (out_item_o),
    .pop        (pop)
  );

endmodule

`default_nettype wire

[tb/daisy_chain_frame_router_test.sv]
// Testbench of the daisy-chain frame router: line bytes and transmit slots go in
// through push/full, every popped item is checked against an in-bench frame parser.
// Depends on dcfr_pkg and daisy_chain_frame_router.
module daisy_chain_frame_router_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dcfr_pkg::*;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned StimTarget = 1850;
  localparam int unsigned TailSlots  = 300;
  localparam logic        KindRx     = 1'b0;
  localparam logic        KindSlot   = 1'b1;
  localparam logic        OutTx      = 1'b0;
  localparam logic        OutEvent   = 1'b1;

  typedef struct packed {
    logic     drain;
    in_item_t item;
  } send_entry_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     push    = 1'b0;
  in_item_t in_item = '0;
  logic     full;
  logic     empty;
  res_t     out_item;
  logic     pop     = 1'b0;

  daisy_chain_frame_router #(
    .MaxPayload(MaxPayload)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_item_i (in_item),
    .full      (full),
    .empty     (empty),
    .out_item_o(out_item),
    .pop       (pop)
  );

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Predicted router state
  phase_e      parse_ph     = PhHunt;
  logic [2:0]  hdr_idx      = '0;
  logic [7:0]  f_type       = '0;
  logic [7:0]  f_src        = '0;
  logic [7:0]  f_dst        = '0;
  logic [15:0] f_len        = '0;
  logic [8:0]  d_cnt        = '0;
  logic [7:0]  payload_buf [MaxPayload];
  logic [7:0]  my_addr      = '0;
  logic        ret_on       = 1'b0;
  reply_e      reply_st     = RpNone;
  logic        fwd_st       = 1'b0;
  logic [8:0]  tx_idx       = '0;
  logic        overrun_flag = 1'b0;
  res_t        expected_results [$];

  // Handshake bookkeeping
  send_entry_t send_queue [$];
  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned stim_count     = 0;
  int unsigned popped_items   = 0;
  int unsigned fail_count     = 0;
  int unsigned send_wait      = 0;
  int unsigned pop_wait       = 0;
  logic        item_taken     = 1'b0;
  logic        res_taken      = 1'b0;
  logic        send_calm      = 1'b0;
  logic        recv_calm      = 1'b0;
  logic [7:0]  gen_addr       = '0;

  function automatic int unsigned draw_wait(input logic calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 10);
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic emit_result(input logic okind, input logic [7:0] txb, input logic last,
                             input action_e act, input logic [7:0] arg,
                             input logic [8:0] len);
    res_t r;
    r.out_kind       = okind;
    r.tx_byte        = txb;
    r.tx_last        = last;
    r.action         = act;
    r.action_arg     = arg;
    r.action_len     = len;
    r.return_enabled = ret_on;
    r.overrun        = overrun_flag;
    expected_results.push_back(r);
  endtask

  // Execute a complete frame and decide reply and forwarding
  task automatic finish_frame();
    logic       evt;
    action_e    act;
    logic [7:0] arg;
    reply_e     rp;
    evt      = 1'b0;
    act      = ActAddrSet;
    arg      = '0;
    parse_ph = PhHunt;
    hdr_idx  = '0;
    tx_idx   = '0;
    reply_st = RpNone;
    if (f_dst == my_addr || f_dst == AddrBcast) begin
      rp = RpAck;
      case (f_type)
        TypeAddrSet: begin
          if (f_len != 16'd1) rp = RpNack;
          else begin
            my_addr = payload_buf[0];
            evt = 1'b1;
            act = ActAddrSet;
            arg = my_addr;
            rp  = RpNone;
          end
        end
        TypeRetOff: begin
          if (f_len != 16'd0) rp = RpNack;
          else begin
            ret_on = 1'b0;
            evt = 1'b1;
            act = ActRetOff;
            rp  = RpNone;
          end
        end
        TypeRetOn: begin
          if (f_len != 16'd0) rp = RpNack;
          else begin
            ret_on = 1'b1;
            evt = 1'b1;
            act = ActRetOn;
          end
        end
        TypePing: begin
          evt = 1'b1;
          act = ActPing;
        end
        TypeStat: begin
          if (f_len != 16'd1) rp = RpNack;
          else begin
            evt = 1'b1;
            act = ActStatus;
            arg = payload_buf[0];
          end
        end
        TypeImgNew: begin
          evt = 1'b1;
          act = ActImgNew;
        end
        TypeImgApp: begin
          evt = 1'b1;
          act = ActImgApp;
        end
        TypePrep: begin
          evt = 1'b1;
          act = ActPrep;
        end
        TypeTrig: begin
          evt = 1'b1;
          act = ActTrigger;
        end
        default: ;
      endcase
      reply_st = rp;
    end
    // Forward decision uses the address after execution
    fwd_st = (f_dst == AddrBcast) || (f_dst != my_addr);
    if (evt) emit_result(OutEvent, 8'h00, 1'b0, act, arg, f_len[8:0]);
  endtask

  // Advance the predicted router by one accepted item
  task automatic route_item(input in_item_t it);
    logic [7:0] txb;
    logic       last;
    logic [7:0] pidx;
    if (it.kind == KindSlot) begin
      if (reply_st != RpNone) begin
        case (tx_idx)
          9'd0:    txb = MagicByte;
          9'd1:    txb = (reply_st == RpNack) ? TypeNack : TypeAck;
          9'd2:    txb = my_addr;
          9'd3:    txb = AddrHost;
          default: txb = 8'h00;
        endcase
        last = (tx_idx >= ReplyLastIdx);
        if (last) begin
          reply_st = RpNone;
          tx_idx   = '0;
        end else begin
          tx_idx++;
        end
        emit_result(OutTx, txb, last, ActAddrSet, 8'h00, 9'd0);
      end else if (fwd_st) begin
        pidx = 8'(tx_idx - 9'(FwdHdrLen));
        case (tx_idx)
          9'd0:    txb = MagicByte;
          9'd1:    txb = f_type;
          9'd2:    txb = f_src;
          9'd3:    txb = f_dst;
          9'd4:    txb = f_len[7:0];
          9'd5:    txb = f_len[15:8];
          default: txb = payload_buf[pidx];
        endcase
        last = (tx_idx + 1 >= FwdHdrLen + f_len);
        if (last) begin
          fwd_st = 1'b0;
          tx_idx = '0;
        end else begin
          tx_idx++;
        end
        emit_result(OutTx, txb, last, ActAddrSet, 8'h00, 9'd0);
      end
    end else if (reply_st != RpNone || fwd_st) begin
      // Drop the byte while output is owed, flag it for good
      overrun_flag = 1'b1;
    end else if (parse_ph == PhHeader) begin
      case (hdr_idx)
        HdrIdxType:  f_type = it.rx_byte;
        HdrIdxSrc:   f_src = it.rx_byte;
        HdrIdxDst:   f_dst = it.rx_byte;
        HdrIdxLenLo: f_len = {8'h00, it.rx_byte};
        default:     f_len = {it.rx_byte, f_len[7:0]};
      endcase
      if (hdr_idx != HdrIdxLenHi) hdr_idx++;
      else begin
        hdr_idx = '0;
        d_cnt   = '0;
        if (f_len > MaxPayload) parse_ph = PhHunt;
        else if (f_len == 16'd0) finish_frame();
        else parse_ph = PhData;
      end
    end else if (parse_ph == PhData) begin
      payload_buf[d_cnt[7:0]] = it.rx_byte;
      d_cnt++;
      if (d_cnt >= f_len) finish_frame();
    end else if (it.rx_byte == MagicByte) begin
      parse_ph = PhHeader;
      hdr_idx  = '0;
    end
  endtask

  // Stimulus construction
  task automatic add_item(input logic k, input logic [7:0] b, input logic counted);
    send_entry_t e;
    e.drain        = 1'b0;
    e.item.kind    = k;
    e.item.rx_byte = b;
    send_queue.push_back(e);
    queued_items++;
    if (counted) stim_count++;
  endtask

  task automatic add_slots(input int unsigned n, input logic counted);
    for (int i = 0; i < n; i++) add_item(KindSlot, 8'($urandom_range(0, 255)), counted);
  endtask

  task automatic add_drain();
    send_entry_t e;
    e       = '0;
    e.drain = 1'b1;
    send_queue.push_back(e);
  endtask

  task automatic add_frame(input logic [7:0] t, input logic [7:0] s, input logic [7:0] d,
                           input logic [15:0] len, input int unsigned slots);
    logic [7:0] b;
    add_item(KindRx, MagicByte, 1'b1);
    add_item(KindRx, t, 1'b1);
    add_item(KindRx, s, 1'b1);
    add_item(KindRx, d, 1'b1);
    add_item(KindRx, len[7:0], 1'b1);
    add_item(KindRx, len[15:8], 1'b1);
    if (len <= MaxPayload) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        // track the address the router should now answer to
        if (i == 0 && len == 16'd1 && t == TypeAddrSet && (d == gen_addr || d == AddrBcast)) begin
          gen_addr = b;
        end
        add_item(KindRx, b, 1'b1);
      end
    end
    add_slots(slots, 1'b1);
  endtask

  // Accept items at the rising edge and predict their results
  always @(posedge clk_i) begin : take_items
    if (rst_ni && push && !full) begin
      item_taken = 1'b1;
      accepted_items++;
      if (accepted_items % 113 == 0) send_calm = ($urandom_range(0, 2) == 0);
      route_item(in_item);
    end
  end

  // Drive the next item at the falling edge
  always @(negedge clk_i) begin : drive_items
    send_entry_t ent;
    logic        next_push;
    if (rst_ni) begin
      next_push = push;
      if (!push || item_taken) begin
        if (item_taken) begin
          item_taken = 1'b0;
          send_wait  = draw_wait(send_calm);
        end
        next_push = 1'b0;
        if (send_wait != 0) send_wait--;
        else if (send_queue.size() != 0) begin
          ent = send_queue[0];
          if (ent.drain) begin
            // hold off until the router has delivered everything owed
            if (expected_results.size() == 0) ent = send_queue.pop_front();
          end else begin
            ent = send_queue.pop_front();
            in_item <= ent.item;
            next_push = 1'b1;
          end
        end
      end
      push <= next_push;
    end
  end

  // Compare each popped item with the oldest prediction
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && pop && !empty) begin
      res_taken = 1'b1;
      popped_items++;
      if (popped_items % 97 == 0) recv_calm = ($urandom_range(0, 2) == 0);
      if (expected_results.size() == 0) begin
        report_mismatch("item with none expected", 64'(out_item), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.out_kind != want.out_kind)
          report_mismatch("out_kind", 64'(out_item.out_kind), 64'(want.out_kind));
        if (out_item.tx_byte != want.tx_byte)
          report_mismatch("tx_byte", 64'(out_item.tx_byte), 64'(want.tx_byte));
        if (out_item.tx_last != want.tx_last)
          report_mismatch("tx_last", 64'(out_item.tx_last), 64'(want.tx_last));
        if (out_item.action != want.action)
          report_mismatch("action", 64'(out_item.action), 64'(want.action));
        if (out_item.action_arg != want.action_arg)
          report_mismatch("action_arg", 64'(out_item.action_arg), 64'(want.action_arg));
        if (out_item.action_len != want.action_len)
          report_mismatch("action_len", 64'(out_item.action_len), 64'(want.action_len));
        if (out_item.return_enabled != want.return_enabled)
          report_mismatch("return_enabled", 64'(out_item.return_enabled),
                          64'(want.return_enabled));
        if (out_item.overrun != want.overrun)
          report_mismatch("overrun", 64'(out_item.overrun), 64'(want.overrun));
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin : drive_pop
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        pop_wait  = draw_wait(recv_calm);
      end
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin : run_test
    logic        rough;
    int unsigned pick;
    int unsigned r;
    int unsigned n;
    int unsigned slots;
    logic [7:0]  t;
    logic [7:0]  d;
    logic [7:0]  b;
    logic [15:0] len;
    for (int i = 0; i < MaxPayload; i++) payload_buf[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle slot and stray bytes at both extremes
    add_item(KindSlot, 8'h00, 1'b1);
    add_item(KindRx, 8'h00, 1'b1);
    add_item(KindRx, 8'hff, 1'b1);
    // Address set at the reset address; the frame then moves on downstream unless the new address is 0
    add_frame(TypeAddrSet, 8'h00, 8'h00, 16'd1, 7);
    // Oversize length at the top of the field, header dropped
    add_frame(TypePing, 8'hff, AddrBcast, 16'hffff, 0);
    add_drain();
    add_item(KindSlot, 8'hff, 1'b1);

    // Largest frame, broadcast: event, reply and full forward
    add_frame(TypePing, 8'h01, AddrBcast, 16'(MaxPayload), 12 + MaxPayload);

    // Random frames; the second half lets output overlap with new bytes
    while (stim_count + TailSlots < StimTarget) begin
      rough = (stim_count > StimTarget / 2);
      pick  = $urandom_range(0, 24);
      if (pick == 0) begin
        add_drain();
      end else if (pick < 3) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (!rough && b == MagicByte) b = 8'h00;
          add_item(KindRx, b, 1'b0);
        end
        add_slots($urandom_range(0, 2), 1'b0);
      end else begin
        case ($urandom_range(0, 10))
          0:       t = TypeAddrSet;
          1:       t = TypeRetOff;
          2:       t = TypeRetOn;
          3:       t = TypePing;
          4:       t = TypeStat;
          5:       t = TypeImgNew;
          6:       t = TypeImgApp;
          7:       t = TypePrep;
          8:       t = TypeTrig;
          9:       t = TypeAck;
          default: t = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
          0:       d = AddrBcast;
          1:       d = 8'($urandom_range(0, 255));
          2:       d = AddrHost;
          default: d = gen_addr;
        endcase
        r = $urandom_range(0, 39);
        if (r == 0) len = 16'($urandom_range(200, MaxPayload));
        else if (r == 1) begin
          case ($urandom_range(0, 2))
            0:       len = 16'(MaxPayload + 1);
            1:       len = 16'hffff;
            default: len = 16'($urandom_range(MaxPayload + 1, 65535));
          endcase
        end else if (r < 4) len = 16'($urandom_range(9, 48));
        else len = 16'($urandom_range(0, 8));
        if ((t == TypeAddrSet || t == TypeStat) && $urandom_range(0, 3) != 0) len = 16'd1;
        if ((t == TypeRetOff || t == TypeRetOn) && $urandom_range(0, 3) != 0) len = 16'd0;
        if (len > MaxPayload) slots = $urandom_range(0, 2);
        else slots = 12 + len + $urandom_range(0, 2);
        // cut the slots short so the next bytes land during output
        if (rough && $urandom_range(0, 2) == 0) slots = $urandom_range(0, slots);
        add_frame(t, 8'($urandom_range(0, 255)), d, len, slots);
      end
    end
    // Drain whatever output is still owed
    add_slots(TailSlots, 1'b0);

    while (accepted_items != queued_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[daisy_chain_frame_router.f]
hw/rtl/dcfr_pkg.sv
hw/rtl/dcfr_front.sv
hw/rtl/dcfr_outq.sv
hw/rtl/dcfr_back.sv
hw/rtl/daisy_chain_frame_router.sv
tb/daisy_chain_frame_router_test.sv
